// ----- rtl/core/mimm_pkg.sv -----
// ----------------------------------------------------------------------------
// mimm_pkg: shared types and constants
// Widths, default stack depth and the divider control structs.
// ----------------------------------------------------------------------------
package mimm_pkg;

    localparam int VAL_W          = 31;   // field width of M, D, L, R, x
    localparam int STACK_DEPTH_DEF = 64;
    localparam int DIVD_W         = 64;   // dividend width of the shared divider
    localparam int CNT_W          = 7;    // holds 64

    typedef struct packed {
        logic start;
        logic long_mode;   // 64 quotient bits, else 33
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_rsp_t;

endpackage

// ----- rtl/core/mimm_div.sv -----
// ----------------------------------------------------------------------------
// mimm_div: shared restoring divider
// One quotient bit per cycle; 33 steps in short mode, 64 in long mode.
// ----------------------------------------------------------------------------
module mimm_div import mimm_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  div_req_t          req,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [VAL_W-1:0]  divisor,
    output div_rsp_t          rsp,
    output logic [DIVD_W-1:0] quotient,
    output logic [VAL_W-1:0]  remainder
);

    logic [VAL_W-1:0]  rem_reg, rem_next;
    logic [DIVD_W-1:0] sh_reg, sh_next;
    logic [VAL_W-1:0]  dv_reg, dv_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [VAL_W:0]    trial;
    logic [VAL_W:0]    diff;
    logic              ge;

    assign trial = {rem_reg, sh_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dv_reg};
    assign ge    = (trial >= {1'b0, dv_reg});

    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dv_next   = dv_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = '0;
            dv_next   = divisor;
            busy_next = 1'b1;
            if (req.long_mode) begin
                sh_next  = dividend;
                cnt_next = CNT_W'(DIVD_W);
            end else begin
                sh_next  = {dividend[32:0], 31'b0};
                cnt_next = CNT_W'(33);
            end
        end else if (busy_reg) begin
            rem_next = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
            sh_next  = {sh_reg[DIVD_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dv_reg  <= dv_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign quotient  = sh_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/core/modular_interval_min_multiplier_core.sv -----
// Division work: each descent level runs two 33-step divisions down and one 64-step
//   division up, on top of the reduction of D modulo M.
// Throughput: one beat in flight; the next beat is taken the cycle after the result leaves.
// Reset: synchronous active-low aresetn clears the sequencer and the output valid;
//   frame memories are not cleared.
// ----------------------------------------------------------------------------
// modular_interval_min_multiplier_core: least x with D*x mod M in [L,R]
// Euclid-like descent over a frame stack, one shared divider under a sequencer.
// ----------------------------------------------------------------------------
module modular_interval_min_multiplier_core import mimm_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [VAL_W-1:0] s_modulus,
    input  logic [VAL_W-1:0] s_multiplier,
    input  logic [VAL_W-1:0] s_range_low,
    input  logic [VAL_W-1:0] s_range_high,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    output logic [VAL_W-1:0] m_least_x
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int IW = $clog2(STACK_DEPTH);
    localparam int SW = VAL_W + 3;   // signed width of the shifted bounds

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RED   = 4'd1;   // D mod M
    localparam logic [3:0] S_CHECK = 4'd2;   // level decision, push frame
    localparam logic [3:0] S_MOD   = 4'd3;   // m mod d
    localparam logic [3:0] S_SHIFT = 4'd4;   // shift window into [0, m)
    localparam logic [3:0] S_UP    = 4'd5;   // pop frame
    localparam logic [3:0] S_MUL   = 4'd6;   // m * y
    localparam logic [3:0] S_UST   = 4'd7;   // start ceiling division
    localparam logic [3:0] S_UDIV  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]            st_reg, st_next;
    logic [VAL_W-1:0]      mm_reg, mm_next;
    logic [VAL_W-1:0]      dd_reg, dd_next;
    logic signed [SW-1:0]  ll_reg, ll_next;
    logic signed [SW-1:0]  rr_reg, rr_next;
    logic [VAL_W:0]        y_reg, y_next;
    logic [LW-1:0]         lvl_reg, lvl_next;
    logic [2*VAL_W:0]      prod_reg;
    logic                  found_reg, found_next;
    logic [VAL_W-1:0]      x_reg, x_next;
    logic                  m_valid_reg, m_valid_next;

    // frame stack
    logic [VAL_W-1:0]      frame_mod  [STACK_DEPTH];
    logic [VAL_W-1:0]      frame_mult [STACK_DEPTH];
    logic [VAL_W:0]        frame_low  [STACK_DEPTH];
    logic [VAL_W-1:0]      rd_mod_reg, rd_mult_reg;
    logic [VAL_W:0]        rd_low_reg;
    logic                  push, pop;

    // divider hookup
    div_req_t              dreq;
    div_rsp_t              drsp;
    logic [DIVD_W-1:0]     dividend;
    logic [VAL_W-1:0]      divisor;
    logic [DIVD_W-1:0]     quot;
    logic [VAL_W-1:0]      rem;

    logic signed [SW-1:0]  mm_s;
    logic signed [SW-1:0]  ll_shift;
    logic [VAL_W-1:0]      r_clamp;
    logic [32:0]           shift_arg;

    assign mm_s = $signed({{(SW-VAL_W){1'b0}}, mm_reg});
    // window shift base: (m'-1) + r, where m' is the old d and r > 0
    assign shift_arg = {2'b0, dd_reg} + {2'b0, rr_reg[VAL_W-1:0]} - 33'd1;
    assign ll_shift  = $signed({{(SW-VAL_W){1'b0}}, mm_reg - VAL_W'(1) - rem});
    assign r_clamp   = (rr_reg[VAL_W-1:0] > mm_reg - VAL_W'(1)) ? mm_reg - VAL_W'(1)
                                                                 : rr_reg[VAL_W-1:0];

    mimm_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (dreq),
        .dividend  (dividend),
        .divisor   (divisor),
        .rsp       (drsp),
        .quotient  (quot),
        .remainder (rem)
    );

    always_comb begin
        st_next      = st_reg;
        mm_next      = mm_reg;
        dd_next      = dd_reg;
        ll_next      = ll_reg;
        rr_next      = rr_reg;
        y_next       = y_reg;
        lvl_next     = lvl_reg;
        found_next   = found_reg;
        x_next       = x_reg;
        m_valid_next = m_valid_reg;
        dreq         = '0;
        dividend     = '0;
        divisor      = mm_reg;
        push         = 1'b0;
        pop          = 1'b0;

        unique case (st_reg)
            S_IDLE: begin
                if (s_valid) begin
                    // latch the beat and reduce D modulo M
                    mm_next  = s_modulus;
                    ll_next  = $signed({{(SW-VAL_W){1'b0}}, s_range_low});
                    rr_next  = $signed({{(SW-VAL_W){1'b0}}, s_range_high});
                    lvl_next = '0;
                    if (s_modulus == '0) begin
                        found_next   = 1'b0;
                        x_next       = '0;
                        m_valid_next = 1'b1;
                        st_next      = S_DONE;
                    end else begin
                        dreq.start = 1'b1;
                        dividend   = {33'b0, s_multiplier};
                        divisor    = s_modulus;
                        st_next    = S_RED;
                    end
                end
            end
            S_RED: begin
                if (drsp.done) begin
                    dd_next = rem;
                    rr_next = $signed({{(SW-VAL_W){1'b0}}, r_clamp});
                    if (ll_reg[VAL_W-1:0] > r_clamp) begin
                        found_next   = 1'b0;
                        x_next       = '0;
                        m_valid_next = 1'b1;
                        st_next      = S_DONE;
                    end else begin
                        // top level needs no shift: the window already sits in [0, m)
                        st_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (ll_reg == '0 || rr_reg >= mm_s) begin
                    y_next  = '0;
                    st_next = S_UP;
                end else if (dd_reg == '0 || lvl_reg == LW'(STACK_DEPTH)) begin
                    found_next   = 1'b0;
                    x_next       = '0;
                    m_valid_next = 1'b1;
                    st_next      = S_DONE;
                end else begin
                    push       = 1'b1;
                    lvl_next   = lvl_reg + LW'(1);
                    dreq.start = 1'b1;
                    dividend   = {33'b0, mm_reg};
                    divisor    = dd_reg;
                    st_next    = S_MOD;
                end
            end
            S_MOD: begin
                if (drsp.done) begin
                    // descend to (d, m mod d, -r, -l), then reduce the window
                    mm_next    = dd_reg;
                    dd_next    = rem;
                    ll_next    = -rr_reg;
                    rr_next    = -ll_reg;
                    dreq.start = 1'b1;
                    dividend   = {31'b0, shift_arg};
                    divisor    = dd_reg;
                    st_next    = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (drsp.done) begin
                    ll_next = ll_shift;
                    rr_next = rr_reg + (ll_shift - ll_reg);
                    st_next = S_CHECK;
                end
            end
            S_UP: begin
                if (lvl_reg == '0) begin
                    found_next   = 1'b1;
                    x_next       = y_reg[VAL_W-1:0];
                    m_valid_next = 1'b1;
                    st_next      = S_DONE;
                end else begin
                    pop      = 1'b1;
                    lvl_next = lvl_reg - LW'(1);
                    st_next  = S_MUL;
                end
            end
            S_MUL: begin
                st_next = S_UST;
            end
            S_UST: begin
                // x = ceil((l + m*y) / d)
                dreq.start     = 1'b1;
                dreq.long_mode = 1'b1;
                dividend       = {32'b0, rd_low_reg} + {1'b0, prod_reg}
                               + {33'b0, rd_mult_reg} - DIVD_W'(1);
                divisor        = rd_mult_reg;
                st_next        = S_UDIV;
            end
            S_UDIV: begin
                if (drsp.done) begin
                    y_next  = quot[VAL_W:0];
                    st_next = S_UP;
                end
            end
            S_DONE: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    st_next      = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mm_reg   <= mm_next;
        dd_reg   <= dd_next;
        ll_reg   <= ll_next;
        rr_reg   <= rr_next;
        y_reg    <= y_next;
        found_reg <= found_next;
        x_reg    <= x_next;
        prod_reg <= rd_mod_reg * y_reg;
        if (!aresetn) begin
            st_reg      <= S_IDLE;
            lvl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            lvl_reg     <= lvl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // frame memories: push writes the current level, pop reads the one below
    always_ff @(posedge aclk) begin
        if (push) begin
            frame_mod[lvl_reg[IW-1:0]]  <= mm_reg;
            frame_mult[lvl_reg[IW-1:0]] <= dd_reg;
            frame_low[lvl_reg[IW-1:0]]  <= ll_reg[VAL_W:0];
        end
        if (pop) begin
            rd_mod_reg  <= frame_mod[lvl_next[IW-1:0]];
            rd_mult_reg <= frame_mult[lvl_next[IW-1:0]];
            rd_low_reg  <= frame_low[lvl_next[IW-1:0]];
        end
    end

    assign s_ready   = (st_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_found   = found_reg;
    assign m_least_x = x_reg;

endmodule

// ----- rtl/core/mimm_checker.sv -----
// ----------------------------------------------------------------------------
// mimm_checker: port-level assertions
// Watches the handshakes and result fields of the core over time.
// ----------------------------------------------------------------------------
module mimm_checker import mimm_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_valid,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic             m_found,
    input logic [VAL_W-1:0] m_least_x
);

    // hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_least_x))
        else $error("result beat changed while stalled");

    // drop x when nothing was found
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_least_x == '0)
        else $error("least_x nonzero on not-found result");

    // one beat in flight: no intake while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("input ready while a result is pending");

    // ready drops the cycle after an intake
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after intake");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind modular_interval_min_multiplier_core mimm_checker u_mimm_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_found   (m_found),
    .m_least_x (m_least_x)
);
